// File: hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies; used by sem_gradient and sobel_edge_magnitude_unit.
package sem_pkg;

    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int OUT_COL_W = 12;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // line store depth; port and counter widths above are sized for it
    localparam int MAX_WIDTH = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [HEIGHT_W-1:0] MIN_DIM      = HEIGHT_W'(3);

    localparam logic [PIX_W-1:0] MAG_MAX = PIX_W'(255);

    typedef logic [PIX_W-1:0] pixel_t;

    // 3x3 neighborhood around the center pixel (center itself unused)
    typedef struct packed {
        pixel_t nw;
        pixel_t nn;
        pixel_t ne;
        pixel_t ww;
        pixel_t ee;
        pixel_t sw;
        pixel_t ss;
        pixel_t se;
    } window_t;

endpackage

// File: hdl/sem_line_store.sv
// One line buffer: single write port, registered read port.
// Depends on nothing; instantiated twice by sobel_edge_magnitude_unit.
module sem_line_store #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/sem_gradient.sv
// Sobel gx/gy kernels and saturated L1 magnitude, purely combinational.
// Depends on sem_pkg (window_t, MAG_MAX).
module sem_gradient (
    input  sem_pkg::window_t win,
    output sem_pkg::pixel_t  magnitude
);
    import sem_pkg::*;

    logic [9:0]         pos_x, neg_x, pos_y, neg_y;
    logic signed [10:0] gx, gy;
    logic [9:0]         abs_x, abs_y;
    logic [10:0]        sum;

    always_comb
    begin
        pos_x = (10'(win.ee) << 1) + 10'(win.ne) + 10'(win.se);
        neg_x = (10'(win.ww) << 1) + 10'(win.sw) + 10'(win.nw);
        pos_y = (10'(win.nn) << 1) + 10'(win.ne) + 10'(win.nw);
        neg_y = (10'(win.ss) << 1) + 10'(win.sw) + 10'(win.se);
        gx    = signed'({1'b0, pos_x}) - signed'({1'b0, neg_x});
        gy    = signed'({1'b0, pos_y}) - signed'({1'b0, neg_y});
        abs_x = gx[10] ? 10'(-gx) : 10'(gx);
        abs_y = gy[10] ? 10'(-gy) : 10'(gy);
        sum   = 11'(abs_x) + 11'(abs_y);
        magnitude = (sum > 11'(MAG_MAX)) ? MAG_MAX : sum[7:0];
    end

endmodule

// File: hdl/sobel_edge_magnitude_unit.sv
// Top level: 3x3 Sobel edge detector with saturated |gx|+|gy| output.
// Depends on sem_pkg, sem_line_store and sem_gradient.
//
// Channel   Dir  Handshake             Beat contents
// in        in   in_valid/in_ready     pixel
// out       out  out_valid/out_ready   magnitude, out_row, out_col, frame_done
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One pixel beat per clock sustained while out does not stall. The pixel that
// completes a window is registered in stage 1 beside the line-store read; its
// result passes the kernel into the output register. Borders give no out beat.
// rst_n clears counters, pipeline valids, the column window and the
// geometry registers (640 x 480); line-store contents come up unknown.
// A stall on out holds the kernel stage, which in turn drops in_ready.
module sobel_edge_magnitude_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  magnitude,
    output logic [15:0] out_row,
    output logic [11:0] out_col,
    output logic        frame_done,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sem_pkg::*;

    // column counter indexes the line stores directly
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WEFF_W > WIDTH_W) ? WEFF_W : WIDTH_W;

    // ---------------------------------------------------------------
    // Geometry registers
    // ---------------------------------------------------------------
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data;
            end
        end
    end

    // Clamp width to [3, MAX_WIDTH] and height to at least 3
    logic [CMP_W-1:0]    width_ext, w_eff;
    logic [COL_W-1:0]    w_last;
    logic [HEIGHT_W-1:0] h_last;

    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(3))
        begin
            w_eff = CMP_W'(3);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end
        w_last = COL_W'(w_eff - CMP_W'(1));
        h_last = ((image_height_reg < MIN_DIM) ? MIN_DIM : image_height_reg)
                 - HEIGHT_W'(1);
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic in_accept, s1_adv;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    // ---------------------------------------------------------------
    // Raster position of the next pixel
    // ---------------------------------------------------------------
    logic [COL_W-1:0]    col_count_reg, col_count_next;
    logic [HEIGHT_W-1:0] row_count_reg, row_count_next;
    logic                at_col_last;

    assign at_col_last = (col_count_reg == w_last);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_hit)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (in_accept)
        begin
            if (at_col_last)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == h_last) ? '0
                                 : row_count_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: pixel and position, line stores read in parallel
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]    s1_pixel_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [HEIGHT_W-1:0] s1_row_reg;
    logic                s1_emit_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
            // interior center lies one row up, one column left
            s1_emit_reg  <= (col_count_reg >= COL_W'(2)) &&
                            (row_count_reg >= HEIGHT_W'(2));
            s1_last_reg  <= at_col_last && (row_count_reg == h_last);
        end
    end

    // upper holds line r-2, middle holds line r-1; written back when
    // the pixel leaves stage 1 (same address read w >= 3 beats later)
    logic [PIX_W-1:0] upper_q, middle_q;

    sem_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (middle_q),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (upper_q)
    );

    sem_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (middle_q)
    );

    // ---------------------------------------------------------------
    // Two-column window: [0..2] = col-2 (n/m/s), [3..5] = col-1
    // ---------------------------------------------------------------
    pixel_t win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_q;
            win_reg[4] <= middle_q;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    window_t win;
    pixel_t  mag;

    always_comb
    begin
        win.nw = win_reg[0];
        win.ww = win_reg[1];
        win.sw = win_reg[2];
        win.nn = win_reg[3];
        win.ss = win_reg[5];
        win.ne = upper_q;
        win.ee = middle_q;
        win.se = s1_pixel_reg;
    end

    sem_gradient u_gradient (
        .win       (win),
        .magnitude (mag)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                 out_load;
    logic [PIX_W-1:0]     magnitude_reg;
    logic [HEIGHT_W-1:0]  out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 frame_done_reg;

    assign out_load = s1_adv && s1_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            magnitude_reg  <= mag;
            out_row_reg    <= s1_row_reg - HEIGHT_W'(1);
            out_col_reg    <= OUT_COL_W'(s1_col_reg - COL_W'(1));
            frame_done_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign magnitude  = magnitude_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_done = frame_done_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a stalled kernel stage keeps its beat
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stage 1 beat dropped under stall");

    // column counter steps by one within a line
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !cfg_hit && !at_col_last
        |=> col_count_reg == $past(col_count_reg) + COL_W'(1))
        else $error("column counter skipped");

    // reported centers never lie on the top border row
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_row_reg != '0))
        else $error("border row reported");

endmodule
